>>> rtl/core/sentence_segmenter_core_assert.svh
// ----------------------------------------------------------------------------
// Sentence segmenter assertion macros
// Shared property forms for the checkers of the segmenter core.
// ----------------------------------------------------------------------------
`ifndef SENTENCE_SEGMENTER_CORE_ASSERT_SVH
`define SENTENCE_SEGMENTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSEG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSEG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sseg_pkg.sv
// ----------------------------------------------------------------------------
// Sentence segmenter package
// Shared constants, character classes and types of the segmenter core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sseg_pkg;

  localparam int BUFFER_BYTES_DEF = 32;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CH_PERIOD   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_QUESTION = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_EXCLAIM  = 8'h21;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_APOS     = 8'h27;
  localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
  localparam logic [BYTE_W-1:0] CH_RPAREN   = 8'h29;
  localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'h7D;

  typedef struct packed {
    logic              seg_last;
    logic [BYTE_W-1:0] seg_byte;
  } out_item_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_closer(input logic [BYTE_W-1:0] c);
    return (c == CH_APOS) || (c == CH_QUOTE) || (c == CH_RPAREN) ||
           (c == CH_RBRACKET) || (c == CH_RBRACE);
  endfunction

  function automatic logic is_term(input logic [BYTE_W-1:0] c);
    return (c == CH_PERIOD) || (c == CH_QUESTION) || (c == CH_EXCLAIM);
  endfunction

endpackage

>>> rtl/core/sentence_segmenter_core.sv
// ----------------------------------------------------------------------------
// Sentence segmenter core
// Splits a byte stream into whitespace-trimmed sentence segments.
// ----------------------------------------------------------------------------
// The input stream carries one text byte per word in in_tdata; in_tuser set
// marks an end-of-text word that carries no byte and flushes the buffer.
// The output stream carries one segment byte per word, with out_tlast on the
// final byte of each segment. Empty segments produce no words.
// A byte that only gets stored is accepted in ST_IDLE and then written into
// the text RAM in ST_APPEND. A flush walks the RAM, one read per cycle while
// the output queue has room, and emits the trimmed bytes; a full-buffer split
// stores the new byte after the walk. The first segment byte passes the RAM
// read register before it enters the output queue.
// Segment bytes pass a two-entry output queue, so a stall on out_tready only
// pauses the RAM walk; the input stays closed until the walk completes.
// Reset clears the fill count, the read pointer and the sentence flag; the
// RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sentence_segmenter_core #(
  parameter int BUFFER_BYTES = sseg_pkg::BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tuser,   // [0] end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] segment_byte
  output logic       out_tlast
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [sseg_pkg::BYTE_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [sseg_pkg::BYTE_W-1:0] rd_data;
  logic [1:0]                  q_free;
  logic                        q_push;
  sseg_pkg::out_item_t         q_item;
  sseg_pkg::out_item_t         out_item;

  sseg_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .AW           (AW),
    .CW           (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_eot   (in_tuser),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .q_free   (q_free),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  sseg_ram #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sseg_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .free_slots (q_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (out_item)
  );

  assign out_tdata = out_item.seg_byte;
  assign out_tlast = out_item.seg_last;

endmodule

>>> rtl/core/sseg_ram.sv
// ----------------------------------------------------------------------------
// Segmenter text RAM
// Single-write, single-read synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sseg_ram #(
  parameter int DEPTH = sseg_pkg::BUFFER_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [sseg_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [sseg_pkg::BYTE_W-1:0] rd_data
);

  logic [sseg_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [sseg_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/sseg_out_fifo.sv
// ----------------------------------------------------------------------------
// Segmenter output queue
// Two-entry queue between the RAM read path and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sseg_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sseg_pkg::out_item_t push_item,
  output logic [1:0]          free_slots,
  output logic                out_valid,
  input  logic                out_ready,
  output sseg_pkg::out_item_t out_item
);

  sseg_pkg::out_item_t entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign out_valid  = (count_r != 2'd0);
  assign out_item   = entry_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;
  assign free_slots = (2'd2 - count_r) + {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/core/sseg_ctrl.sv
// ----------------------------------------------------------------------------
// Segmenter control
// Keeps the ring pointers and trim marks, and sequences stores and flushes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sseg_ctrl #(
  parameter int BUFFER_BYTES = sseg_pkg::BUFFER_BYTES_DEF,
  parameter int AW           = $clog2(BUFFER_BYTES),
  parameter int CW           = $clog2(BUFFER_BYTES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sseg_pkg::BYTE_W-1:0] in_byte,
  input  logic                        in_eot,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [sseg_pkg::BYTE_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [sseg_pkg::BYTE_W-1:0] rd_data,
  input  logic [1:0]                  q_free,
  output logic                        q_push,
  output sseg_pkg::out_item_t         q_item
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FLUSH  = 2'd1;
  localparam logic [1:0] ST_APPEND = 2'd2;
  localparam logic [1:0] ST_DRAIN  = 2'd3;

  localparam logic [CW-1:0] FULL = CW'(BUFFER_BYTES);
  localparam logic [CW:0]   WRAP = (CW + 1)'(BUFFER_BYTES);

  logic [1:0]                  state_r, state_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               fill_r, fill_nxt;
  logic [CW-1:0]               cut_r, cut_nxt;
  logic [CW-1:0]               cut_hi_r, cut_hi_nxt;
  logic [CW-1:0]               first_ns_r, first_ns_nxt;
  logic [CW-1:0]               last_ns_r, last_ns_nxt;
  logic                        has_ns_r, has_ns_nxt;
  logic                        pending_r, pending_nxt;
  logic                        rd_v_r, rd_v_nxt;
  logic                        rd_last_r, rd_last_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               end_r, end_nxt;
  logic [CW-1:0]               len_r, len_nxt;
  logic                        then_append_r, then_append_nxt;
  logic                        space_path_r, space_path_nxt;
  logic [sseg_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic [CW-1:0]               split_len;
  logic [CW-1:0]               split_hi;
  logic                        can_issue;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (sum >= WRAP) begin
      sum = sum - WRAP;
    end
    return sum[AW-1:0];
  endfunction

  assign split_len = (cut_r != '0) ? cut_r : fill_r;
  assign split_hi  = (cut_r != '0) ? cut_hi_r : last_ns_r;
  assign can_issue = rd_v_r ? (q_free == 2'd2) : (q_free != 2'd0);

  assign in_ready = (state_r == ST_IDLE);
  assign q_push   = rd_v_r;
  assign q_item   = '{seg_last: rd_last_r, seg_byte: rd_data};
  assign rd_addr  = wrap_add(head_r, idx_r);
  assign wr_addr  = wrap_add(head_r, fill_r);
  assign wr_data  = byte_r;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    cut_nxt         = cut_r;
    cut_hi_nxt      = cut_hi_r;
    first_ns_nxt    = first_ns_r;
    last_ns_nxt     = last_ns_r;
    has_ns_nxt      = has_ns_r;
    pending_nxt     = pending_r;
    rd_v_nxt        = 1'b0;
    rd_last_nxt     = rd_last_r;
    idx_nxt         = idx_r;
    end_nxt         = end_r;
    len_nxt         = len_r;
    then_append_nxt = then_append_r;
    space_path_nxt  = space_path_r;
    byte_nxt        = byte_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_byte;
          if (in_eot) begin
            if (fill_r != '0) begin
              idx_nxt         = first_ns_r;
              end_nxt         = last_ns_r;
              len_nxt         = fill_r;
              then_append_nxt = 1'b0;
              state_nxt       = ST_FLUSH;
            end
          end else begin
            space_path_nxt = pending_r && sseg_pkg::is_space(in_byte);
            if (!(pending_r && sseg_pkg::is_space(in_byte))) begin
              pending_nxt = pending_r && sseg_pkg::is_closer(in_byte);
            end
            if (fill_r == FULL) begin
              idx_nxt         = first_ns_r;
              end_nxt         = split_hi;
              len_nxt         = split_len;
              then_append_nxt = 1'b1;
              state_nxt       = ST_FLUSH;
            end else begin
              state_nxt = ST_APPEND;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (idx_r < end_r) begin
          if (can_issue) begin
            rd_en       = 1'b1;
            rd_v_nxt    = 1'b1;
            rd_last_nxt = ((idx_r + CW'(1)) == end_r);
            idx_nxt     = idx_r + CW'(1);
          end
        end else begin
          head_nxt    = wrap_add(head_r, len_r);
          fill_nxt    = fill_r - len_r;
          pending_nxt = 1'b0;
          cut_nxt     = '0;
          cut_hi_nxt  = '0;
          first_ns_nxt = '0;
          if (len_r == fill_r) begin
            has_ns_nxt  = 1'b0;
            last_ns_nxt = '0;
          end else begin
            has_ns_nxt  = 1'b1;
            last_ns_nxt = fill_r - len_r;
          end
          state_nxt = then_append_r ? ST_APPEND : ST_IDLE;
        end
      end
      ST_APPEND: begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + CW'(1);
        if (sseg_pkg::is_space(byte_r)) begin
          cut_nxt    = fill_r + CW'(1);
          cut_hi_nxt = last_ns_r;
        end else begin
          last_ns_nxt = fill_r + CW'(1);
          if (!has_ns_r) begin
            first_ns_nxt = fill_r;
            has_ns_nxt   = 1'b1;
          end
        end
        if (sseg_pkg::is_term(byte_r)) begin
          pending_nxt = 1'b1;
        end
        state_nxt = space_path_r ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        idx_nxt         = first_ns_r;
        end_nxt         = last_ns_r;
        len_nxt         = fill_r;
        then_append_nxt = 1'b0;
        state_nxt       = ST_FLUSH;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_r     <= '0;
      fill_r     <= '0;
      cut_r      <= '0;
      cut_hi_r   <= '0;
      first_ns_r <= '0;
      last_ns_r  <= '0;
      has_ns_r   <= 1'b0;
      pending_r  <= 1'b0;
      rd_v_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      fill_r     <= fill_nxt;
      cut_r      <= cut_nxt;
      cut_hi_r   <= cut_hi_nxt;
      first_ns_r <= first_ns_nxt;
      last_ns_r  <= last_ns_nxt;
      has_ns_r   <= has_ns_nxt;
      pending_r  <= pending_nxt;
      rd_v_r     <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r     <= rd_last_nxt;
    idx_r         <= idx_nxt;
    end_r         <= end_nxt;
    len_r         <= len_nxt;
    then_append_r <= then_append_nxt;
    space_path_r  <= space_path_nxt;
    byte_r        <= byte_nxt;
  end

endmodule

>>> rtl/core/sseg_checker.sv
// ----------------------------------------------------------------------------
// Segmenter port checker
// Watches the ports of the segmenter core and is bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sentence_segmenter_core_assert.svh"

module sseg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic seg_start_r;
  logic in_byte_acc;
  logic out_acc;

  assign in_byte_acc = in_tvalid && in_tready && !in_tuser;
  assign out_acc     = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_start_r <= 1'b1;
    end else if (out_acc) begin
      seg_start_r <= out_tlast;
    end
  end

  `SSEG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast),
    "Stalled output word changed or dropped.")

  `SSEG_ASSERT_NEXT(a_byte_store_busy, clk, rst_n, in_byte_acc, !in_tready,
    "Input accepted a second word before the stored byte was written.")

  `SSEG_ASSERT_NOW(a_no_leading_space, clk, rst_n, out_tvalid && seg_start_r,
    !sseg_pkg::is_space(out_tdata), "Segment starts with whitespace.")

  `SSEG_ASSERT_NOW(a_no_trailing_space, clk, rst_n, out_tvalid && out_tlast,
    !sseg_pkg::is_space(out_tdata), "Segment ends with whitespace.")

endmodule

bind sentence_segmenter_core sseg_checker u_sseg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
